[rtl/prf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Position frame receiver package
// Shared constants, status codes, register indexes and types used by the
// front end, the job queue, the result back end and the top level.
// ----------------------------------------------------------------------------
package prf_pkg;

	// Default frame geometry, handed to the top-level parameters.
	localparam int FRAME_LEN_DEF   = 19;
	localparam int LASER_WORDS_DEF = 4;
	localparam int RECT_WORDS_DEF  = 4;

	// Fixed depth of the location store and widths of the word fields.
	localparam int STORE_DEPTH = 8;
	localparam int WORD_W      = 16;
	localparam int BYTE_W      = 8;
	localparam int IDX_W       = 3;
	localparam int CFG_ADDR_W  = 1;

	// Depth of the queue between front end and back end.
	localparam int QUEUE_DEPTH = 2;

	// Reset values of the configuration registers.
	localparam logic [BYTE_W-1:0] HEADER_RST  = 8'h12;
	localparam logic [BYTE_W-1:0] TRAILER_RST = 8'h5B;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_W-1:0] REG_HEADER  = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_TRAILER = 1'b1;

	// Target status codes.
	typedef enum logic [1:0] {
		ST_FOUND = 2'd0,
		ST_NEVER = 2'd1,
		ST_LOST  = 2'd2,
		ST_BAD   = 2'd3
	} status_t;

	// Whole location store as one packed vector of words.
	typedef logic [STORE_DEPTH-1:0][WORD_W-1:0] word_arr_t;

	// One job handed from the front end to the back end per accepted byte.
	typedef struct packed {
		status_t laser;
		status_t rect;
		logic    complete;
	} job_t;

	// Grade one target from its status after the header check, its updated
	// never-seen bit and whether all of its words are zero.
	function automatic status_t grade_status(status_t st, logic never_seen, logic empty);
		status_t r;
		if (st == ST_BAD) begin
			r = ST_BAD;
		end else if (!empty) begin
			r = ST_FOUND;
		end else if (never_seen) begin
			r = ST_NEVER;
		end else begin
			r = ST_LOST;
		end
		return r;
	endfunction

endpackage

[rtl/prf_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Position frame receiver channel interfaces
// Valid/ready channels for received bytes, result words and register writes.
// ----------------------------------------------------------------------------

// Received byte channel.
interface prf_byte_if
	import prf_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink (input valid, input byte_in, output ready);
endinterface

// Result word channel.
interface prf_result_if
	import prf_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [1:0]        laser_status;
	logic [1:0]        rect_status;
	logic              word_valid;
	logic [IDX_W-1:0]  word_index;
	logic [WORD_W-1:0] word_value;
	logic              last;

	modport source (output valid, output laser_status, output rect_status,
		output word_valid, output word_index, output word_value, output last,
		input ready);
	modport sink (input valid, input laser_status, input rect_status,
		input word_valid, input word_index, input word_value, input last,
		output ready);
endinterface

// Register write channel.
interface prf_cfg_if
	import prf_pkg::*;
	();
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [BYTE_W-1:0]     data;

	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

[rtl/prf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Position frame receiver front end
// Accepts bytes, tracks the frame position, stages location pairs, commits
// them to the location store on a good trailer and grades both targets.
// ----------------------------------------------------------------------------
module prf_front
	import prf_pkg::*;
	#(
		parameter int FRAME_LEN   = FRAME_LEN_DEF,
		parameter int LASER_WORDS = LASER_WORDS_DEF,
		parameter int RECT_WORDS  = RECT_WORDS_DEF
	)
	(
		input  logic       clk,
		input  logic       arst_n,
		prf_byte_if.sink   rx,
		prf_cfg_if.sink    cfg,
		output job_t       job,
		output logic       job_push,
		input  logic       q_full,
		input  logic       done_complete,
		output word_arr_t  store
	);

	localparam int PW        = $clog2(FRAME_LEN);
	localparam int PAIR_FIT  = (FRAME_LEN - 3) / 2;
	localparam int NPAIR     = (PAIR_FIT < STORE_DEPTH) ? PAIR_FIT : STORE_DEPTH;
	localparam logic [PW-1:0] POS_LAST  = PW'(FRAME_LEN - 1);
	localparam logic [PW-1:0] POS_COUNT = PW'(1);

	logic [BYTE_W-1:0] header_q;
	logic [BYTE_W-1:0] trailer_q;
	logic [PW-1:0]     pos_q;
	logic [BYTE_W-1:0] count_q;
	logic [WORD_W-1:0] stage_q [NPAIR];
	word_arr_t         store_q;
	status_t           laser_q;
	status_t           rect_q;
	logic              laser_never_q;
	logic              rect_never_q;
	logic              pend_q;

	logic              accept;
	logic              bad;
	logic              complete;
	logic [PW-1:0]     pos_nx;
	status_t           laser_h;
	status_t           rect_h;
	word_arr_t         store_nx;
	logic              laser_empty;
	logic              rect_empty;
	logic              laser_never_nx;
	logic              rect_never_nx;
	status_t           laser_nx;
	status_t           rect_nx;

	// Registers are always writable; the user must change them only while the block is idle, which is not enforced.
	assign cfg.ready = 1'b1;

	// A frame end waits while the previous frame's words are still going out.
	assign rx.ready = !q_full && !((pos_q == POS_LAST) && pend_q);
	assign accept   = rx.valid && rx.ready;

	// Header and trailer checks and the next frame position.
	always_comb begin
		bad      = 1'b0;
		complete = 1'b0;
		pos_nx   = pos_q;
		laser_h  = laser_q;
		rect_h   = rect_q;
		if (pos_q == '0) begin
			if (rx.byte_in != header_q) begin
				bad = 1'b1;
			end else begin
				if (laser_q == ST_BAD) laser_h = ST_FOUND;
				if (rect_q == ST_BAD) rect_h = ST_FOUND;
				pos_nx = PW'(1);
			end
		end else if (pos_q == POS_LAST) begin
			if (rx.byte_in != trailer_q) begin
				bad = 1'b1;
			end else begin
				pos_nx   = '0;
				complete = 1'b1;
			end
		end else begin
			pos_nx = pos_q + 1'b1;
		end
		if (bad) begin
			pos_nx  = '0;
			laser_h = ST_BAD;
			rect_h  = ST_BAD;
		end
	end

	// Store contents after this byte: staged pairs within the count commit.
	always_comb begin
		store_nx = store_q;
		if (complete) begin
			for (int j = 0; j < NPAIR; j++) begin
				if (BYTE_W'(2 * j) < count_q) store_nx[j] = stage_q[j];
			end
		end
	end

	// All-zero checks over each target's words; words past the store read as zero.
	always_comb begin
		laser_empty = 1'b1;
		rect_empty  = 1'b1;
		for (int i = 0; i < STORE_DEPTH; i++) begin
			if (i < LASER_WORDS && store_nx[i] != '0) laser_empty = 1'b0;
			if (i >= LASER_WORDS && i < LASER_WORDS + RECT_WORDS && store_nx[i] != '0) begin
				rect_empty = 1'b0;
			end
		end
	end

	// Grading.
	assign laser_never_nx = laser_never_q && (laser_h == ST_NEVER);
	assign rect_never_nx  = rect_never_q && (rect_h == ST_NEVER);
	assign laser_nx       = grade_status(laser_h, laser_never_nx, laser_empty);
	assign rect_nx        = grade_status(rect_h, rect_never_nx, rect_empty);

	assign job.laser    = laser_nx;
	assign job.rect     = rect_nx;
	assign job.complete = complete;
	assign job_push     = accept;
	assign store        = store_q;

	// Control state, configuration and the location store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q      <= HEADER_RST;
			trailer_q     <= TRAILER_RST;
			pos_q         <= '0;
			count_q       <= '0;
			store_q       <= '0;
			laser_q       <= ST_NEVER;
			rect_q        <= ST_NEVER;
			laser_never_q <= 1'b1;
			rect_never_q  <= 1'b1;
			pend_q        <= 1'b0;
		end else begin
			if (cfg.valid) begin
				if (cfg.addr == REG_HEADER) header_q <= cfg.data;
				if (cfg.addr == REG_TRAILER) trailer_q <= cfg.data;
			end
			if (accept) begin
				pos_q         <= pos_nx;
				store_q       <= store_nx;
				laser_q       <= laser_nx;
				rect_q        <= rect_nx;
				laser_never_q <= laser_never_nx;
				rect_never_q  <= rect_never_nx;
				if (pos_q == POS_COUNT) count_q <= rx.byte_in;
			end
			if (accept && complete) begin
				pend_q <= 1'b1;
			end else if (done_complete) begin
				pend_q <= 1'b0;
			end
		end
	end

	// Staging of location pairs, high byte first.
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int j = 0; j < NPAIR; j++) begin
				if (pos_q == PW'(2 * j + 2)) stage_q[j][WORD_W-1:BYTE_W] <= rx.byte_in;
				if (pos_q == PW'(2 * j + 3)) stage_q[j][BYTE_W-1:0] <= rx.byte_in;
			end
		end
	end

endmodule

[rtl/prf_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Position frame receiver job queue
// Short FIFO of graded jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module prf_queue
	import prf_pkg::*;
	(
		input  logic clk,
		input  logic arst_n,
		input  logic push,
		input  job_t wdata,
		output logic full,
		input  logic pop,
		output job_t rdata,
		output logic empty
	);

	localparam int AW = $clog2(QUEUE_DEPTH);

	job_t          mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   cnt_q;

	assign full  = (cnt_q == (AW + 1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

endmodule

[rtl/prf_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Position frame receiver back end
// Takes jobs from the queue and sends one status word per byte, or the
// target location words after a completed frame, through an output register.
// ----------------------------------------------------------------------------
module prf_back
	import prf_pkg::*;
	#(
		parameter int LASER_WORDS = LASER_WORDS_DEF,
		parameter int RECT_WORDS  = RECT_WORDS_DEF
	)
	(
		input  logic         clk,
		input  logic         arst_n,
		input  job_t         head,
		input  logic         q_empty,
		output logic         pop,
		output logic         done_complete,
		input  word_arr_t    store,
		prf_result_if.source res
	);

	localparam int TOTAL   = LASER_WORDS + RECT_WORDS;
	localparam int NUM_RES = (TOTAL < STORE_DEPTH) ? TOTAL : STORE_DEPTH;
	localparam logic [IDX_W-1:0] K_LAST = IDX_W'(NUM_RES - 1);

	typedef enum logic {
		S_IDLE,
		S_EMIT
	} state_t;

	state_t            state_q;
	job_t              job_q;
	logic [IDX_W-1:0]  k_q;
	logic              valid_q;
	status_t           laser_q;
	status_t           rect_q;
	logic              word_valid_q;
	logic [IDX_W-1:0]  word_index_q;
	logic [WORD_W-1:0] word_value_q;
	logic              last_q;

	logic              load;
	logic              emitting;
	logic              last_w;

	// The output register can take a word when empty or being drained.
	assign load          = !valid_q || res.ready;
	assign pop           = (state_q == S_IDLE) && !q_empty;
	assign emitting      = (state_q == S_EMIT) && load;
	assign last_w        = !job_q.complete || (k_q == K_LAST);
	assign done_complete = emitting && job_q.complete && last_w;

	assign res.valid        = valid_q;
	assign res.laser_status = laser_q;
	assign res.rect_status  = rect_q;
	assign res.word_valid   = word_valid_q;
	assign res.word_index   = word_index_q;
	assign res.word_value   = word_value_q;
	assign res.last         = last_q;

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= 1'b0;
			k_q          <= '0;
			job_q        <= '0;
			laser_q      <= ST_NEVER;
			rect_q       <= ST_NEVER;
			word_valid_q <= 1'b0;
			word_index_q <= '0;
			word_value_q <= '0;
			last_q       <= 1'b0;
		end else begin
			// A drained word empties the register unless a new one loads.
			if (res.ready && !emitting) valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						job_q   <= head;
						k_q     <= '0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (load) begin
						valid_q      <= 1'b1;
						laser_q      <= job_q.laser;
						rect_q       <= job_q.rect;
						word_valid_q <= job_q.complete;
						word_index_q <= job_q.complete ? k_q : '0;
						word_value_q <= job_q.complete ? store[k_q] : '0;
						last_q       <= last_w;
						k_q          <= k_q + 1'b1;
						if (last_w) state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/position_frame_receiver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Position frame receiver
// Parses fixed-length header/count/words/trailer frames from a byte stream,
// keeps the location store and grades the laser and rectangle targets.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Word
//  rx       in   byte_in
//  res      out  laser_status, rect_status, word_valid, word_index,
//                word_value, last
//  cfg      in   addr (0 header, 1 trailer), data
//
// The front end takes one byte per cycle while the two-entry job queue has
// room. The back end takes a job, then sends one status word for an ordinary
// byte or min(LASER_WORDS + RECT_WORDS, 8) location words for a frame end
// before the next job. A frame-end byte is held off while the previous
// frame's words are still being sent. Reset clears all state but the staged
// pairs and queue entries. A stalled result holds in the output register;
// the front end keeps accepting until the queue fills.
// ----------------------------------------------------------------------------
module position_frame_receiver
	import prf_pkg::*;
	#(
		parameter int FRAME_LEN   = FRAME_LEN_DEF,
		parameter int LASER_WORDS = LASER_WORDS_DEF,
		parameter int RECT_WORDS  = RECT_WORDS_DEF
	)
	(
		input  logic         clk,
		input  logic         arst_n,
		prf_byte_if.sink     rx,
		prf_result_if.source res,
		prf_cfg_if.sink      cfg
	);

	job_t      job;
	job_t      head;
	logic      job_push;
	logic      q_full;
	logic      q_empty;
	logic      pop;
	logic      done_complete;
	word_arr_t store;

	// Byte parsing and grading.
	prf_front #(
		.FRAME_LEN   (FRAME_LEN),
		.LASER_WORDS (LASER_WORDS),
		.RECT_WORDS  (RECT_WORDS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx            (rx),
		.cfg           (cfg),
		.job           (job),
		.job_push      (job_push),
		.q_full        (q_full),
		.done_complete (done_complete),
		.store         (store)
	);

	// Jobs waiting for the result side.
	prf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job),
		.full   (q_full),
		.pop    (pop),
		.rdata  (head),
		.empty  (q_empty)
	);

	// Result sequencing.
	prf_back #(
		.LASER_WORDS (LASER_WORDS),
		.RECT_WORDS  (RECT_WORDS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_empty       (q_empty),
		.pop           (pop),
		.done_complete (done_complete),
		.store         (store),
		.res           (res)
	);

endmodule
